### rtl/nsc_pkg.sv
// Package with the shared constants, the token type and the modular adder.
`default_nettype none

package nsc_pkg;

  localparam int NUM_VALUES = 32;
  localparam int VALUE_W = 6;
  localparam int IDX_W = VALUE_W + 1;
  localparam int COUNT_W = 30;
  localparam logic [COUNT_W-1:0] PRIME = COUNT_W'(1000000007);

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] acc;
  } token_t;

  function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, PRIME}) begin
      sum = sum - {1'b0, PRIME};
    end
    return sum[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/nsc_cell.sv
// One cell of the chain: the counter of one value and the token stage after it.
`default_nettype none

module nsc_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic [nsc_pkg::IDX_W-1:0] cell_value,
  input  wire nsc_pkg::token_t       token_in,
  output nsc_pkg::token_t            token_out
);
  import nsc_pkg::*;

  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_eff;
  logic [COUNT_W-1:0] fresh;
  logic [COUNT_W-1:0] cnt_next;
  logic               hit;
  token_t             token_next;

  always_comb begin
    cnt_eff = token_in.first ? '0 : cnt;
    hit = token_in.valid && ({1'b0, token_in.value} == cell_value);
    fresh = add_mod(token_in.acc, cnt_eff);
    cnt_next = hit ? add_mod(cnt_eff, fresh) : cnt_eff;
    token_next = token_in;
    // Past the element's own cell the total grows by each count; at that cell
    // the prefix plus the updated count equals twice the new subsequences.
    token_next.acc = hit ? add_mod(fresh, fresh) : fresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      token_out <= '0;
    end else if (adv) begin
      token_out <= token_next;
      if (token_in.valid) begin
        cnt <= cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/nondecreasing_subsequence_counter.sv
// Top level: the chain of value cells and the result register.
// Items enter one per cycle unless stalled and travel down a chain of NUM_VALUES
// cells, one cell per cycle; each cell holds the counter of one value and
// updates it as an item passes, so later items always see the updates of
// earlier ones. A last item's answer passes the cell registers and then the
// count register. The whole chain stalls only while a finished result waits
// in the output register and the next result reaches the end of the chain.
`default_nettype none

module nondecreasing_subsequence_counter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire logic [nsc_pkg::VALUE_W-1:0] value,
  input  wire logic                        first,
  input  wire logic                        last,
  output logic                             count_valid,
  input  wire logic                        count_ready,
  output logic [nsc_pkg::COUNT_W-1:0]      count
);
  import nsc_pkg::*;

  token_t chain [NUM_VALUES+1];
  token_t head;
  token_t tail;
  logic   adv;

  always_comb begin
    head.valid = item_valid;
    head.first = first;
    head.last = last;
    head.value = value;
    head.acc = COUNT_W'(1);
  end

  assign chain[0] = head;

  always_comb begin
    tail = chain[NUM_VALUES];
    adv = !(tail.valid && tail.last && count_valid && !count_ready);
    item_ready = adv;
  end

  for (genvar g = 0; g < NUM_VALUES; g++) begin : g_cell
    nsc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .cell_value(IDX_W'(g + 1)),
      .token_in  (chain[g]),
      .token_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (adv && tail.valid && tail.last) begin
      count_valid <= 1'b1;
    end else if (count_ready) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail.valid && tail.last) begin
      count <= tail.acc;
    end
  end

endmodule

`default_nettype wire

### rtl/nsc_checker.sv
// Port checker for the counter and its bind to the top level.
`default_nettype none

module nsc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_valid,
  input wire logic                        item_ready,
  input wire logic [nsc_pkg::VALUE_W-1:0] value,
  input wire logic                        first,
  input wire logic                        last,
  input wire logic                        count_valid,
  input wire logic                        count_ready,
  input wire logic [nsc_pkg::COUNT_W-1:0] count
);
  import nsc_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !count_valid)
    else $error("Result valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    count_valid && !count_ready |=> count_valid && $stable(count))
    else $error("Waiting result changed.");

  a_range: assert property (@(posedge clk) disable iff (rst)
    count_valid |-> count < PRIME)
    else $error("Result not reduced modulo the prime.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> count_valid && !count_ready)
    else $error("Input stalled while the output was free.");

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable({value, first, last}))
    else $error("Waiting item changed.");

endmodule

bind nondecreasing_subsequence_counter nsc_checker u_nsc_checker (.*);

`default_nettype wire

### bench/count_checker.sv
// Checker that predicts the subsequence counts from the accepted items and compares the answers.
`timescale 1ns / 1ps

module subseq_count_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  input  wire logic                        item_ready,
  input  wire logic [nsc_pkg::VALUE_W-1:0] value,
  input  wire logic                        first,
  input  wire logic                        last,
  input  wire logic                        count_valid,
  input  wire logic                        count_ready,
  input  wire logic [nsc_pkg::COUNT_W-1:0] count,
  output int                               mismatches,
  output int                               pending,
  output int                               answers_checked
);

  import nsc_pkg::*;

  logic [COUNT_W-1:0] ends_at [NUM_VALUES];
  logic [COUNT_W-1:0] expected_counts [$];

  function automatic logic [COUNT_W-1:0] mod_sum(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    if (s >= longint'(PRIME)) begin
      s -= longint'(PRIME);
    end
    return s[COUNT_W-1:0];
  endfunction

  task automatic absorb_element(input logic [VALUE_W-1:0] v, input logic f, input logic l);
    logic [COUNT_W-1:0] ways;
    logic [COUNT_W-1:0] total;
    int slot;
    if (f) begin
      foreach (ends_at[i]) ends_at[i] = '0;
    end
    if (v >= 1 && v <= NUM_VALUES) begin
      slot = int'(v) - 1;
      ways = COUNT_W'(1);
      for (int i = 0; i <= slot; i++) ways = mod_sum(ways, ends_at[i]);
      ends_at[slot] = mod_sum(ends_at[slot], ways);
    end
    if (l) begin
      total = COUNT_W'(1);
      for (int i = 0; i < NUM_VALUES; i++) total = mod_sum(total, ends_at[i]);
      expected_counts.push_back(total);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [COUNT_W-1:0] want;
    if (rst) begin
      foreach (ends_at[i]) ends_at[i] = '0;
      expected_counts.delete();
      mismatches = 0;
      answers_checked = 0;
    end else begin
      if (count_valid && count_ready) begin
        if (expected_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Count %0d arrived with no answer pending.", count);
          end
        end else begin
          want = expected_counts.pop_front();
          answers_checked++;
          if (count !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Answer %0d: expected count %0d, got %0d.", answers_checked, want,
                       count);
            end
          end
        end
      end
      if (item_valid && item_ready) begin
        absorb_element(value, first, last);
      end
    end
    pending = expected_counts.size();
  end

endmodule

### bench/tb.sv
// Testbench top: drives query streams with random idling into the counter and reports the verdict.
`timescale 1ns / 1ps

module tb;

  import nsc_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int ALL_ONES_VALUE = (1 << VALUE_W) - 1;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic [VALUE_W-1:0] value;
  logic               first;
  logic               last;
  logic               count_valid;
  logic               count_ready;
  logic [COUNT_W-1:0] count;

  int mismatches;
  int pending;
  int answers_checked;

  logic item_taken;
  bit   quiet;
  int   items_sent;
  int   items_effective;
  int   items_out_of_range;

  nondecreasing_subsequence_counter dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .value      (value),
    .first      (first),
    .last       (last),
    .count_valid(count_valid),
    .count_ready(count_ready),
    .count      (count)
  );

  subseq_count_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .value          (value),
    .first          (first),
    .last           (last),
    .count_valid    (count_valid),
    .count_ready    (count_ready),
    .count          (count),
    .mismatches     (mismatches),
    .pending        (pending),
    .answers_checked(answers_checked)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    item_taken <= item_valid && item_ready;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    count_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        count_ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      count_ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  task automatic send_item(input int v, input bit f, input bit l);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    item_valid = 1'b1;
    value = VALUE_W'(v);
    first = f;
    last = l;
    do @(negedge clk); while (!item_taken);
    items_sent++;
    if (v < 1 || v > NUM_VALUES) items_out_of_range++;
    if ((v >= 1 && v <= NUM_VALUES) || f || l) items_effective++;
  endtask

  task automatic hold_until_drained();
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int len;
    int lo;
    int span;
    int kind;
    int v;
    bit f;
    bit l;
    bit paused;
    rst = 1'b1;
    item_valid = 1'b0;
    value = '0;
    first = 1'b0;
    last = 1'b0;
    quiet = 1'b0;
    paused = 1'b0;
    items_sent = 0;
    items_effective = 0;
    items_out_of_range = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // A single-element query, then repeats of the largest value.
    send_item(1, 1'b1, 1'b1);
    send_item(NUM_VALUES, 1'b1, 1'b0);
    send_item(NUM_VALUES, 1'b0, 1'b0);
    send_item(NUM_VALUES, 1'b0, 1'b1);
    // Out-of-range values inside a query are skipped.
    send_item(5, 1'b1, 1'b0);
    send_item(0, 1'b0, 1'b0);
    send_item(ALL_ONES_VALUE, 1'b0, 1'b0);
    send_item(NUM_VALUES + 1, 1'b0, 1'b0);
    send_item(4, 1'b0, 1'b1);
    // A query without a first mark continues from the previous counters; then queries ending on out-of-range values.
    send_item(2, 1'b0, 1'b1);
    send_item(0, 1'b1, 1'b1);
    send_item(17, 1'b0, 1'b0);
    send_item(1, 1'b0, 1'b0);
    send_item(42, 1'b0, 1'b1);
    send_item(31, 1'b1, 1'b0);
    send_item(16, 1'b0, 1'b0);
    send_item(8, 1'b0, 1'b1);
    send_item(NUM_VALUES + 1, 1'b1, 1'b1);
    hold_until_drained();

    while (items_effective < RANDOM_ITEMS) begin
      if (!paused && items_effective >= RANDOM_ITEMS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      quiet = (items_effective >= RANDOM_ITEMS - 200);
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      if (kind >= 93) len = $urandom_range(1, 6);
      lo = $urandom_range(1, NUM_VALUES);
      span = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : NUM_VALUES - 1;
      for (int i = 0; i < len; i++) begin
        v = ((lo - 1 + $urandom_range(0, span)) % NUM_VALUES) + 1;
        f = (i == 0);
        l = (i == len - 1);
        if (kind >= 75 && kind < 85 && $urandom_range(0, 3) == 0) begin
          v = $urandom_range(0, 1) ? 0 : $urandom_range(NUM_VALUES + 1, ALL_ONES_VALUE);
        end
        if (kind >= 85 && kind < 93) f = 1'b0;
        if (kind >= 93) begin
          v = $urandom_range(0, ALL_ONES_VALUE);
          f = 1'($urandom_range(0, 1));
          l = 1'($urandom_range(0, 1));
        end
        send_item(v, f, l);
      end
    end

    item_valid = 1'b0;
    for (int n = 0; n < 20000 && pending != 0; n++) @(negedge clk);
    repeat (NUM_VALUES + 8) @(negedge clk);

    $display("Sent %0d items, %0d of them out of range, and checked %0d answers.",
             items_sent, items_out_of_range, answers_checked);
    $display("Queries were well formed, unmarked, mixed with noise, with idling on both sides.");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
